/* sv/heap_sort_engine_unit_defines.svh */
// ----------------------------------------------------------------------------
// Heap sort engine assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef HEAP_SORT_ENGINE_UNIT_DEFINES_SVH
`define HEAP_SORT_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication
`define HSE_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HSE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/hse_pkg.sv */
// ----------------------------------------------------------------------------
// Heap sort engine package
// Default sizes and the child-selection control word of the sift step.
// ----------------------------------------------------------------------------
package hse_pkg;

	localparam int MAX_COUNT_DEF  = 64;
	localparam int DATA_WIDTH_DEF = 32;

	// outcome of one sift-down comparison
	typedef struct packed {
		logic take_right; // right child is the larger child
		logic descend;    // larger child beats the value being sifted
	} pick_t;

endpackage

/* sv/hse_pick.sv */
// ----------------------------------------------------------------------------
// Heap sort engine child pick
// Compares the two children of a node against the value being sifted down.
// ----------------------------------------------------------------------------
module hse_pick #(
	parameter int DATA_WIDTH = hse_pkg::DATA_WIDTH_DEF
) (
	input  logic [DATA_WIDTH-1:0] sift_val,
	input  logic [DATA_WIDTH-1:0] left_val,
	input  logic [DATA_WIDTH-1:0] right_val,
	input  logic                  has_right,
	output hse_pkg::pick_t        pick
);

	logic                  right_big;
	logic [DATA_WIDTH-1:0] child_val;

	// larger of the two children, then against the sifted value (signed order)
	always_comb begin
		right_big       = has_right && ($signed(right_val) > $signed(left_val));
		child_val       = right_big ? right_val : left_val;
		pick.take_right = right_big;
		pick.descend    = $signed(child_val) > $signed(sift_val);
	end

endmodule

/* sv/heap_sort_engine_unit.sv */
// ----------------------------------------------------------------------------
// Heap sort engine
// Collects a set of signed values, heap-sorts it in place, streams it out.
// ----------------------------------------------------------------------------
// Items are taken one per cycle while the block is idle into a single-port-style
// store of MAX_COUNT entries (one write and one registered read per cycle);
// items past capacity are dropped and every result of that set carries tuser
// high. The item with tlast starts the sort; the input is not ready during the
// sort and the emission that follows. The sort is a sequencer around the store:
// each sift level reads the left child, reads the right child, then compares and
// writes back, and each sift start first loads the value to be sifted. Results
// are then read out of the store one at a time, each held until it is taken, and
// a new set is taken only once the last result of the old one has gone.
// ----------------------------------------------------------------------------
`include "heap_sort_engine_unit_defines.svh"

module heap_sort_engine_unit #(
	parameter  int MAX_COUNT  = hse_pkg::MAX_COUNT_DEF,
	parameter  int DATA_WIDTH = hse_pkg::DATA_WIDTH_DEF,
	localparam int TDATA_W    = ((DATA_WIDTH + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [TDATA_W-1:0] s_axis_tdata,  // [DATA_WIDTH-1:0] value, rest zero
	input  logic               s_axis_tlast,  // last
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata,  // [DATA_WIDTH-1:0] value_res, rest zero
	output logic               m_axis_tlast,  // last_res
	output logic               m_axis_tuser   // overflow
);

	localparam int AW = $clog2(MAX_COUNT);
	localparam int NW = $clog2(MAX_COUNT + 1);
	localparam int CW = NW + 1;
	localparam logic [NW-1:0] MAXN = NW'(MAX_COUNT);
	localparam logic [NW-1:0] ONE  = NW'(1);
	localparam logic [NW-1:0] TWO  = NW'(2);

	// sequencer states
	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_B_RD   = 4'd1;
	localparam logic [3:0] ST_B_LD   = 4'd2;
	localparam logic [3:0] ST_SD_L   = 4'd3;
	localparam logic [3:0] ST_SD_R   = 4'd4;
	localparam logic [3:0] ST_SD_C   = 4'd5;
	localparam logic [3:0] ST_SD_END = 4'd6;
	localparam logic [3:0] ST_X_RE   = 4'd7;
	localparam logic [3:0] ST_X_R1   = 4'd8;
	localparam logic [3:0] ST_X_W    = 4'd9;
	localparam logic [3:0] ST_E_RD   = 4'd10;
	localparam logic [3:0] ST_E_LD   = 4'd11;
	localparam logic [3:0] ST_E_WAIT = 4'd12;

	logic [3:0]            state_q;
	logic [NW-1:0]         cnt_q;
	logic                  drop_q;
	logic [NW-1:0]         n_q;
	logic [NW-1:0]         bk_q;
	logic [NW-1:0]         end_q;
	logic [NW-1:0]         k_q;
	logic [NW-1:0]         sz_q;
	logic [NW-1:0]         ei_q;
	logic                  sort_ph_q;
	logic [DATA_WIDTH-1:0] v_q;
	logic [DATA_WIDTH-1:0] l_q;
	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] out_data_q;
	logic                  out_last_q;
	logic                  out_ovf_q;

	// element store
	logic [DATA_WIDTH-1:0] mem_q [MAX_COUNT];
	logic [DATA_WIDTH-1:0] rdat_q;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [DATA_WIDTH-1:0] wr_data;

	logic                  in_acc;
	logic                  has_room;
	logic [NW-1:0]         new_n;
	logic [DATA_WIDTH-1:0] in_val;
	logic [CW-1:0]         lc;
	logic [CW-1:0]         rc;
	logic [CW-1:0]         lc_m1;
	logic                  has_l;
	logic                  has_r;
	logic [NW-1:0]         k_m1;
	logic [NW-1:0]         bk_m1;
	logic [NW-1:0]         end_m1;
	logic [NW-1:0]         ei_m1;
	logic [DATA_WIDTH-1:0] child_val;
	hse_pkg::pick_t        pick;

	// handshake and ingest
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign in_val        = s_axis_tdata[DATA_WIDTH-1:0];
	assign has_room      = (cnt_q < MAXN);
	assign new_n         = has_room ? (cnt_q + ONE) : cnt_q;

	// node arithmetic, 1-based nodes to 0-based addresses
	assign lc     = {k_q, 1'b0};
	assign rc     = lc + CW'(1);
	assign lc_m1  = lc - CW'(1);
	assign has_l  = (lc <= {1'b0, sz_q});
	assign has_r  = (rc <= {1'b0, sz_q});
	assign k_m1   = k_q - ONE;
	assign bk_m1  = bk_q - ONE;
	assign end_m1 = end_q - ONE;
	assign ei_m1  = ei_q - ONE;

	hse_pick #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_pick (
		.sift_val  (v_q),
		.left_val  (l_q),
		.right_val (rdat_q),
		.has_right (has_r),
		.pick      (pick)
	);

	assign child_val = pick.take_right ? rdat_q : l_q;

	// store port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = v_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && has_room) begin
					wr_en   = 1'b1;
					wr_addr = cnt_q[AW-1:0];
					wr_data = in_val;
				end
			end
			ST_B_RD: begin
				rd_en   = 1'b1;
				rd_addr = bk_m1[AW-1:0];
			end
			ST_SD_L: begin
				if (has_l) begin
					rd_en   = 1'b1;
					rd_addr = lc_m1[AW-1:0];
				end else begin
					wr_en   = 1'b1;
					wr_addr = k_m1[AW-1:0];
				end
			end
			ST_SD_R: begin
				if (has_r) begin
					rd_en   = 1'b1;
					rd_addr = lc[AW-1:0];
				end
			end
			ST_SD_C: begin
				wr_en   = 1'b1;
				wr_addr = k_m1[AW-1:0];
				wr_data = pick.descend ? child_val : v_q;
			end
			ST_X_RE: begin
				rd_en   = 1'b1;
				rd_addr = end_m1[AW-1:0];
			end
			ST_X_R1: begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end
			ST_X_W: begin
				wr_en   = 1'b1;
				wr_addr = end_m1[AW-1:0];
				wr_data = rdat_q;
			end
			ST_E_RD: begin
				rd_en   = 1'b1;
				rd_addr = ei_m1[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	// store array, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdat_q <= mem_q[rd_addr];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			drop_q      <= 1'b0;
			n_q         <= '0;
			bk_q        <= '0;
			end_q       <= '0;
			k_q         <= '0;
			sz_q        <= '0;
			ei_q        <= '0;
			sort_ph_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						cnt_q <= new_n;
						if (!has_room) begin
							drop_q <= 1'b1;
						end
						if (s_axis_tlast) begin
							n_q       <= new_n;
							sort_ph_q <= 1'b0;
							if (new_n >= TWO) begin
								bk_q    <= new_n >> 1;
								state_q <= ST_B_RD;
							end else begin
								ei_q    <= ONE;
								state_q <= ST_E_RD;
							end
						end
					end
				end
				ST_B_RD: begin
					state_q <= ST_B_LD;
				end
				ST_B_LD: begin
					k_q     <= bk_q;
					sz_q    <= n_q;
					state_q <= ST_SD_L;
				end
				ST_SD_L: begin
					state_q <= has_l ? ST_SD_R : ST_SD_END;
				end
				ST_SD_R: begin
					state_q <= ST_SD_C;
				end
				ST_SD_C: begin
					if (pick.descend) begin
						k_q     <= pick.take_right ? rc[NW-1:0] : lc[NW-1:0];
						state_q <= ST_SD_L;
					end else begin
						state_q <= ST_SD_END;
					end
				end
				ST_SD_END: begin
					if (!sort_ph_q) begin
						if (bk_q == ONE) begin
							sort_ph_q <= 1'b1;
							end_q     <= n_q;
							state_q   <= ST_X_RE;
						end else begin
							bk_q    <= bk_m1;
							state_q <= ST_B_RD;
						end
					end else if (end_q == TWO) begin
						ei_q    <= ONE;
						state_q <= ST_E_RD;
					end else begin
						end_q   <= end_m1;
						state_q <= ST_X_RE;
					end
				end
				ST_X_RE: begin
					state_q <= ST_X_R1;
				end
				ST_X_R1: begin
					state_q <= ST_X_W;
				end
				ST_X_W: begin
					k_q     <= ONE;
					sz_q    <= end_m1;
					state_q <= ST_SD_L;
				end
				ST_E_RD: begin
					state_q <= ST_E_LD;
				end
				ST_E_LD: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_E_WAIT;
				end
				ST_E_WAIT: begin
					if (m_axis_tready) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							cnt_q   <= '0;
							drop_q  <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							ei_q    <= ei_q + ONE;
							state_q <= ST_E_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers: sifted value, left child, output item
	always_ff @(posedge clk) begin
		if (state_q == ST_B_LD || state_q == ST_X_R1) begin
			v_q <= rdat_q;
		end
		if (state_q == ST_SD_R) begin
			l_q <= rdat_q;
		end
		if (state_q == ST_E_LD) begin
			out_data_q <= rdat_q;
			out_last_q <= (ei_q == n_q);
			out_ovf_q  <= drop_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = TDATA_W'(out_data_q);
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_ovf_q;

	// checks
	`HSE_ASSERT_IMPL(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= MAXN, "fill count past capacity")
	`HSE_ASSERT_IMPL(a_no_overlap, clk, arst_n, m_axis_tvalid, !s_axis_tready, "input ready during emission")
	`HSE_ASSERT_IMPL(a_sift_node, clk, arst_n, state_q == ST_SD_L, (k_q != '0) && (k_q <= sz_q), "sift node outside heap")
	`HSE_ASSERT_IMPL(a_emit_idx, clk, arst_n, state_q == ST_E_LD, (ei_q != '0) && (ei_q <= n_q), "emit index outside set")
	`HSE_ASSERT_NEXT(a_last_stops, clk, arst_n, in_acc && s_axis_tlast, !s_axis_tready, "input still ready after last item")

endmodule

/* test/hse_sort_checker.sv */
// ----------------------------------------------------------------------------
// Heap sort engine checker
// Watches both stream channels, keeps its own sorted copy of the set being
// collected and compares every emitted item with the expected ascending run.
// ----------------------------------------------------------------------------
module hse_sort_checker #(
	parameter int MAX_COUNT  = hse_pkg::MAX_COUNT_DEF,
	parameter int DATA_WIDTH = hse_pkg::DATA_WIDTH_DEF,
	parameter int TDATA_W    = ((DATA_WIDTH + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	input  logic               s_axis_tready,
	input  logic [TDATA_W-1:0] s_axis_tdata,  // [DATA_WIDTH-1:0] value, rest zero
	input  logic               s_axis_tlast,  // last
	input  logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	input  logic [TDATA_W-1:0] m_axis_tdata,  // [DATA_WIDTH-1:0] value_res, rest zero
	input  logic               m_axis_tlast,  // last_res
	input  logic               m_axis_tuser,  // overflow
	output int                 error_count,
	output int                 results_due,
	output int                 items_taken,
	output int                 results_seen,
	output int                 sets_sorted,
	output int                 sets_dropped
);

	typedef logic signed [DATA_WIDTH-1:0] elem_t;

	typedef struct {
		elem_t value;
		logic  last;
		logic  overflow;
	} sorted_out_t;

	// set being collected, held in ascending order as it arrives
	elem_t       held_set[$];
	logic        dropped;
	// ascending runs still to be emitted by the block
	sorted_out_t sorted_due[$];

	initial begin
		dropped      = 1'b0;
		error_count  = 0;
		results_due  = 0;
		items_taken  = 0;
		results_seen = 0;
		sets_sorted  = 0;
		sets_dropped = 0;
	end

	// store one value; a last item releases the whole set as sorted output
	task automatic take_value(input elem_t v, input logic is_last);
		int          pos;
		sorted_out_t r;
		if (held_set.size() < MAX_COUNT) begin
			pos = 0;
			while (pos < held_set.size() && held_set[pos] <= v)
				pos++;
			held_set.insert(pos, v);
		end else begin
			dropped = 1'b1;
		end
		if (is_last) begin
			foreach (held_set[i]) begin
				r.value    = held_set[i];
				r.last     = (i == held_set.size() - 1);
				r.overflow = dropped;
				sorted_due.push_back(r);
			end
			sets_sorted++;
			if (dropped)
				sets_dropped++;
			held_set.delete();
			dropped = 1'b0;
		end
	endtask

	// compare one emitted item with the oldest expectation
	task automatic check_result();
		sorted_out_t want;
		elem_t       got;
		got = $signed(m_axis_tdata[DATA_WIDTH-1:0]);
		results_seen++;
		if (sorted_due.size() == 0) begin
			error_count++;
			$display("%0t: unexpected item: value %0d last %0b overflow %0b",
				$time, got, m_axis_tlast, m_axis_tuser);
		end else begin
			want = sorted_due.pop_front();
			if (got !== want.value || m_axis_tlast !== want.last ||
			    m_axis_tuser !== want.overflow) begin
				error_count++;
				$display("%0t: mismatch: expected value %0d last %0b overflow %0b, got value %0d last %0b overflow %0b",
					$time, want.value, want.last, want.overflow,
					got, m_axis_tlast, m_axis_tuser);
			end
		end
	endtask

	// both channels sampled on the same edge as the block sees them
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				items_taken++;
				take_value($signed(s_axis_tdata[DATA_WIDTH-1:0]), s_axis_tlast);
			end
			if (m_axis_tvalid && m_axis_tready)
				check_result();
			results_due = sorted_due.size();
		end
	end

endmodule

/* test/tb_heap_sort_engine_unit.sv */
// ----------------------------------------------------------------------------
// Heap sort engine testbench
// Streams sets of signed values into the sorter in random bursts, stalls the
// output on a pattern of its own and lets the checker compare each run.
// ----------------------------------------------------------------------------
module tb_heap_sort_engine_unit;

	localparam int MAX_COUNT    = hse_pkg::MAX_COUNT_DEF;
	localparam int DATA_WIDTH   = hse_pkg::DATA_WIDTH_DEF;
	localparam int TDATA_W      = ((DATA_WIDTH + 7) / 8) * 8;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 40;

	localparam logic [DATA_WIDTH-1:0] VAL_MIN  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam logic [DATA_WIDTH-1:0] VAL_MAX  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] VAL_ZERO = '0;
	localparam logic [DATA_WIDTH-1:0] VAL_NEG1 = '1;

	// output stall patterns
	typedef enum int {
		RX_OPEN,
		RX_HALF,
		RX_MOSTLY,
		RX_CHOKED
	} rx_mode_e;

	logic               clk;
	logic               arst_n;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [TDATA_W-1:0] s_axis_tdata;
	logic               s_axis_tlast;
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [TDATA_W-1:0] m_axis_tdata;
	logic               m_axis_tlast;
	logic               m_axis_tuser;

	int error_count;
	int results_due;
	int items_taken;
	int results_seen;
	int sets_sorted;
	int sets_dropped;
	int burst_left;
	int cycle_count;

	heap_sort_engine_unit #(
		.MAX_COUNT  (MAX_COUNT),
		.DATA_WIDTH (DATA_WIDTH)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	hse_sort_checker #(
		.MAX_COUNT  (MAX_COUNT),
		.DATA_WIDTH (DATA_WIDTH),
		.TDATA_W    (TDATA_W)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.error_count   (error_count),
		.results_due   (results_due),
		.items_taken   (items_taken),
		.results_seen  (results_seen),
		.sets_sorted   (sets_sorted),
		.sets_dropped  (sets_dropped)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d items still due", cycle_count, results_due);
			$display("tb_heap_sort_engine_unit: done, errors");
			$finish;
		end
	end

	// value mix: full range, a narrow band around zero for duplicates, extremes
	function automatic logic [DATA_WIDTH-1:0] pick_value();
		int                    sel;
		int                    k;
		logic [DATA_WIDTH-1:0] v;
		sel = $urandom_range(0, 9);
		if (sel < 5) begin
			v = DATA_WIDTH'({$urandom, $urandom});
		end else if (sel < 7) begin
			k = $urandom_range(0, 8);
			v = DATA_WIDTH'(k - 4);
		end else if (sel == 7) begin
			k = $urandom_range(0, 3);
			v = (k == 0) ? VAL_MIN : (k == 1) ? VAL_MAX : (k == 2) ? VAL_ZERO : VAL_NEG1;
		end else if (sel == 8) begin
			v = VAL_MIN + DATA_WIDTH'($urandom_range(0, 3));
		end else begin
			v = VAL_MAX - DATA_WIDTH'($urandom_range(0, 3));
		end
		return v;
	endfunction

	// offer one item; bursts of random length with random gaps between them
	task automatic push_value(input logic [DATA_WIDTH-1:0] v, input logic is_last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) :
				$urandom_range(1, 8);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= TDATA_W'(v);
		s_axis_tlast  <= is_last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		burst_left--;
	endtask

	task automatic send_set(input int n);
		for (int i = 0; i < n; i++)
			push_value(pick_value(), i == n - 1);
	endtask

	// sets of mostly small, random size until about n_items have gone
	task automatic small_sets(input int n_items);
		int sent;
		int size;
		sent = 0;
		while (sent < n_items) begin
			size = ($urandom_range(0, 7) == 0) ? 2 : $urandom_range(1, 10);
			send_set(size);
			sent += size;
		end
	endtask

	// output stalls
	initial begin : rx_pattern
		rx_mode_e mode;
		int       span;
		m_axis_tready <= 1'b0;
		forever begin
			mode = rx_mode_e'($urandom_range(0, 3));
			span = $urandom_range(5, 40);
			repeat (span) begin
				@(posedge clk);
				case (mode)
					RX_OPEN:   m_axis_tready <= 1'b1;
					RX_HALF:   m_axis_tready <= ($urandom_range(0, 1) == 1);
					RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 4) != 0);
					default:   m_axis_tready <= ($urandom_range(0, 5) == 0);
				endcase
			end
		end
	end

	// stimulus and verdict
	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tlast  <= 1'b0;
		burst_left    = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single element set at the most negative value
		push_value(VAL_MIN, 1'b1);
		// extremes, sign boundary, alternating bit patterns and duplicates
		push_value(VAL_MAX, 1'b0);
		push_value(VAL_MIN, 1'b0);
		push_value(VAL_ZERO, 1'b0);
		push_value(VAL_NEG1, 1'b0);
		push_value(DATA_WIDTH'(1), 1'b0);
		push_value(VAL_MAX, 1'b0);
		push_value(VAL_MIN, 1'b0);
		push_value({(DATA_WIDTH/2){2'b01}}, 1'b0);
		push_value({(DATA_WIDTH/2){2'b10}}, 1'b1);
		// two equal values
		push_value(DATA_WIDTH'(5), 1'b0);
		push_value(DATA_WIDTH'(5), 1'b1);
		// two in descending order
		push_value(VAL_MAX, 1'b0);
		push_value(VAL_NEG1, 1'b1);

		// random sets, one exactly full and one overrunning with the items past capacity dropped
		small_sets(10);
		send_set(MAX_COUNT);
		small_sets(6);
		send_set(MAX_COUNT + $urandom_range(1, 3));
		small_sets(4);
		s_axis_tvalid <= 1'b0;

		@(negedge clk);
		while (results_due != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sorted %0d sets (%0d of them past capacity) from %0d items", sets_sorted,
			sets_dropped, items_taken);
		$display("checked %0d sorted items, %0d errors", results_seen, error_count);
		if (error_count == 0)
			$display("tb_heap_sort_engine_unit: done, clean");
		else
			$display("tb_heap_sort_engine_unit: done, errors");
		$finish;
	end

endmodule
